// ===== sv/rrqs_pkg.sv =====
`timescale 1ns / 1ps
// Package for the round-robin quantum scheduler.
// Shared constants, codes and the result transaction type; no dependencies.
package rrqs_pkg;
    localparam int unsigned DEF_MAX_JOBS = 16;
    localparam logic [7:0]  QUANTUM_RESET = 8'd4;

    localparam logic MODE_ARRIVE = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_TIME  = 2'd1,
        ST_LIST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] now;
        logic        running;
        logic [7:0]  run_job_id;
        logic        done_valid;
        logic [7:0]  done_user;
        logic [31:0] done_time;
    } t_result;
endpackage

// ===== sv/rrqs_in_if.sv =====
`timescale 1ns / 1ps
// Input channel: job arrival or tick transaction.
// Depends on nothing.
interface rrqs_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [7:0]  job_id;
    logic [7:0]  user_id;
    logic [31:0] arrival_time;
    logic [15:0] job_length;
    modport source (output valid, mode, job_id, user_id, arrival_time, job_length,
                    input ready);
    modport sink   (input valid, mode, job_id, user_id, arrival_time, job_length,
                    output ready);
endinterface

// ===== sv/rrqs_out_if.sv =====
`timescale 1ns / 1ps
// Result channel of the scheduler.
// Depends on nothing.
interface rrqs_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] now;
    logic        running;
    logic [7:0]  run_job_id;
    logic        done_valid;
    logic [7:0]  done_user;
    logic [31:0] done_time;
    modport source (output valid, status, now, running, run_job_id, done_valid,
                    done_user, done_time, input ready);
    modport sink   (input valid, status, now, running, run_job_id, done_valid,
                    done_user, done_time, output ready);
endinterface

// ===== sv/rrqs_cfg_if.sv =====
`timescale 1ns / 1ps
// Configuration write channel carrying the quantum register.
// Depends on nothing.
interface rrqs_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== sv/rrqs_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module rrqs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/rrqs_free.sv =====
`timescale 1ns / 1ps
// Free-slot mask and lowest-free-slot finder.
// Depends on rrqs_pkg.
module rrqs_free import rrqs_pkg::*; #(
    parameter int unsigned MAX_JOBS = DEF_MAX_JOBS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_alloc,
    input  logic                        i_release,
    input  logic [$clog2(MAX_JOBS)-1:0] i_rel_slot,
    output logic [$clog2(MAX_JOBS)-1:0] o_slot
);
    localparam int unsigned AW = $clog2(MAX_JOBS);

    logic [MAX_JOBS-1:0] r_free;
    logic [MAX_JOBS-1:0] n_free;

    always_comb begin
        o_slot = '0;
        for (int i = MAX_JOBS - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                o_slot = AW'(i);
            end
        end
    end

    always_comb begin
        n_free = r_free;
        if (i_alloc) begin
            n_free[o_slot] = 1'b0;
        end
        if (i_release) begin
            n_free[i_rel_slot] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= '1;
        end else begin
            r_free <= n_free;
        end
    end
endmodule

// ===== sv/round_robin_quantum_scheduler.sv =====
`timescale 1ns / 1ps
// Round-robin scheduler with a time quantum; job list kept in one RAM.
// Arrival: result registered at accept when dropped; when queued, after S_A_LINK
// (non-empty list) and S_A_NEW. Tick: result registered at accept when idle,
// else after S_T_CUR and the unlink and run steps, each a RAM read or write-back.
// One transaction in flight; next accept once the result has been taken.
// Synchronous active-low reset; RAM contents are not cleared.
module round_robin_quantum_scheduler import rrqs_pkg::*; #(
    parameter int unsigned MAX_JOBS = DEF_MAX_JOBS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rrqs_in_if.sink      i_item,
    rrqs_out_if.source   o_result,
    rrqs_cfg_if.sink     i_cfg
);
    localparam int unsigned AW = $clog2(MAX_JOBS);
    localparam int unsigned OW = $clog2(MAX_JOBS + 1);

    typedef struct packed {
        logic [7:0]    job;
        logic [7:0]    user;
        logic [15:0]   rem;
        logic [AW-1:0] nxt;
        logic [AW-1:0] prv;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE, S_A_LINK, S_A_NEW, S_T_CUR, S_T_PRV_RD, S_T_PRV_WB,
        S_T_NXT_RD, S_T_NXT_WB, S_T_RUN_RD, S_T_RUN
    } t_state;

    t_state        r_state;
    logic [7:0]    r_quantum;
    logic [7:0]    r_ql;
    logic [31:0]   r_tick;
    logic [AW-1:0] r_head;
    logic [AW-1:0] r_tail;
    logic [OW-1:0] r_occ;
    logic [AW-1:0] r_cur;
    logic          r_cv;
    logic          r_is_tail;
    logic [AW-1:0] r_slot;
    t_entry        r_new;
    t_entry        r_e;
    t_result       r_out;
    logic          r_out_valid;

    logic          acc;
    logic          arr_ok;
    logic          is_head;
    logic          is_tail;
    logic          rel;
    logic [AW-1:0] free_slot;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_entry        ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    t_entry        rd;

    assign i_item.ready = (r_state == S_IDLE) && !r_out_valid;
    assign acc          = i_item.valid && i_item.ready;
    assign arr_ok       = acc && (i_item.mode == MODE_ARRIVE)
                          && (i_item.arrival_time == r_tick + 32'd1)
                          && (r_occ != OW'(MAX_JOBS));
    assign is_head      = (r_cur == r_head);
    assign is_tail      = (r_cur == r_tail);
    assign rel          = (r_state == S_T_CUR) && (rd.rem == 16'd0);
    assign i_cfg.ready  = 1'b1;

    assign o_result.valid      = r_out_valid;
    assign o_result.status     = r_out.status;
    assign o_result.now        = r_out.now;
    assign o_result.running    = r_out.running;
    assign o_result.run_job_id = r_out.run_job_id;
    assign o_result.done_valid = r_out.done_valid;
    assign o_result.done_user  = r_out.done_user;
    assign o_result.done_time  = r_out.done_time;

    rrqs_free #(.MAX_JOBS(MAX_JOBS)) u_free (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_alloc    (arr_ok),
        .i_release  (rel),
        .i_rel_slot (r_cur),
        .o_slot     (free_slot)
    );

    rrqs_ram #(.WIDTH($bits(t_entry)), .DEPTH(MAX_JOBS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd)
    );

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cur;
        ram_wdata = rd;
        ram_re    = 1'b0;
        ram_raddr = r_cur;
        case (r_state)
            S_IDLE: begin
                if (acc && i_item.mode == MODE_TICK && r_cv) begin
                    ram_re = 1'b1;
                end else if (arr_ok && r_occ != '0) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_tail;
                end
            end
            S_A_LINK: begin
                ram_we        = 1'b1;
                ram_waddr     = r_new.prv;
                ram_wdata.nxt = r_slot;
            end
            S_A_NEW: begin
                ram_we    = 1'b1;
                ram_waddr = r_slot;
                ram_wdata = r_new;
            end
            S_T_PRV_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_e.prv;
            end
            S_T_PRV_WB: begin
                ram_we        = 1'b1;
                ram_waddr     = r_e.prv;
                ram_wdata.nxt = r_e.nxt;
            end
            S_T_NXT_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_e.nxt;
            end
            S_T_NXT_WB: begin
                ram_we        = 1'b1;
                ram_waddr     = r_e.nxt;
                ram_wdata.prv = r_e.prv;
            end
            S_T_RUN_RD: begin
                ram_re = r_cv;
            end
            S_T_RUN: begin
                ram_we        = (rd.rem != 16'd0);
                ram_wdata.rem = rd.rem - 16'd1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_quantum   <= QUANTUM_RESET;
            r_ql        <= QUANTUM_RESET;
            r_tick      <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_cur       <= '0;
            r_cv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_out <= '0;
                        if (i_item.mode == MODE_ARRIVE) begin
                            r_out.now <= r_tick + 32'd1;
                            if (i_item.arrival_time != r_tick + 32'd1) begin
                                r_out.status <= ST_BAD_TIME;
                                r_out_valid  <= 1'b1;
                            end else if (!arr_ok) begin
                                r_out.status <= ST_LIST_FULL;
                                r_out_valid  <= 1'b1;
                            end else begin
                                r_out.status <= ST_OK;
                                r_slot       <= free_slot;
                                r_new        <= '{job: i_item.job_id, user: i_item.user_id,
                                                  rem: i_item.job_length, nxt: '0,
                                                  prv: r_tail};
                                r_tail       <= free_slot;
                                r_occ        <= r_occ + OW'(1);
                                if (r_occ == '0) begin
                                    r_head <= free_slot;
                                end
                                if (!r_cv) begin
                                    r_cur <= (r_occ == '0) ? free_slot : r_head;
                                    r_cv  <= 1'b1;
                                end
                                r_state <= (r_occ == '0) ? S_A_NEW : S_A_LINK;
                            end
                        end else begin
                            r_tick    <= r_tick + 32'd1;
                            r_out.now <= r_tick + 32'd1;
                            if (r_cv) begin
                                r_state <= S_T_CUR;
                            end else begin
                                r_out_valid <= 1'b1;
                            end
                        end
                    end
                end
                S_A_LINK: begin
                    r_state <= S_A_NEW;
                end
                S_A_NEW: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                S_T_CUR: begin
                    r_e       <= rd;
                    r_is_tail <= is_tail;
                    if (rd.rem == 16'd0) begin
                        r_out.done_valid <= 1'b1;
                        r_out.done_user  <= rd.user;
                        r_out.done_time  <= r_tick - 32'd1;
                        r_occ            <= r_occ - OW'(1);
                        r_cv             <= (r_occ != OW'(1));
                        r_ql             <= r_quantum - 8'd1;
                        if (is_head && !is_tail) begin
                            r_head <= rd.nxt;
                            r_cur  <= rd.nxt;
                        end else begin
                            r_cur <= r_head;
                        end
                        if (is_tail && !is_head) begin
                            r_tail <= rd.prv;
                        end
                        if (!is_head) begin
                            r_state <= S_T_PRV_RD;
                        end else if (!is_tail) begin
                            r_state <= S_T_NXT_RD;
                        end else begin
                            r_state <= S_T_RUN_RD;
                        end
                    end else begin
                        if (r_ql == 8'd0) begin
                            r_ql <= r_quantum - 8'd1;
                            if (!is_tail) begin
                                r_cur <= rd.nxt;
                            end
                        end else begin
                            r_ql <= r_ql - 8'd1;
                        end
                        r_state <= S_T_RUN_RD;
                    end
                end
                S_T_PRV_RD: begin
                    r_state <= S_T_PRV_WB;
                end
                S_T_PRV_WB: begin
                    r_state <= r_is_tail ? S_T_RUN_RD : S_T_NXT_RD;
                end
                S_T_NXT_RD: begin
                    r_state <= S_T_NXT_WB;
                end
                S_T_NXT_WB: begin
                    r_state <= S_T_RUN_RD;
                end
                S_T_RUN_RD: begin
                    if (r_cv) begin
                        r_state <= S_T_RUN;
                    end else begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_T_RUN: begin
                    if (rd.rem != 16'd0) begin
                        r_out.running    <= 1'b1;
                        r_out.run_job_id <= rd.job;
                    end
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (i_cfg.valid) begin
                r_quantum <= i_cfg.data;
                r_ql      <= i_cfg.data;
            end
        end
    end
endmodule

// ===== sv/rrqs_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the scheduler, bound to the top level.
// Depends on rrqs_pkg and round_robin_quantum_scheduler.
module rrqs_checker import rrqs_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_status,
    input logic [31:0] i_now,
    input logic        i_running,
    input logic        i_done_valid,
    input logic [31:0] i_done_time
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input taken while a result is pending");

    a_drop_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_OK |-> !i_running && !i_done_valid)
        else $error("dropped arrival reports activity");

    a_done_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_done_valid |-> i_done_time == i_now - 32'd1)
        else $error("finish time mismatch");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");
endmodule

bind round_robin_quantum_scheduler rrqs_checker u_rrqs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_item.ready),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_status     (o_result.status),
    .i_now        (o_result.now),
    .i_running    (o_result.running),
    .i_done_valid (o_result.done_valid),
    .i_done_time  (o_result.done_time)
);
